>>> hw/rtl/quadtree_node_bit_packer_top_assert.svh
// ---------------------------------------------------------------------------
// Quadtree node bit packer assertion macros
// Clocked concurrent checks on clk; compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef QUADTREE_NODE_BIT_PACKER_TOP_ASSERT_SVH
`define QUADTREE_NODE_BIT_PACKER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define QNBP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qnbp: check failed");
`define QNBP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("qnbp: check failed");
`else
`define QNBP_ASSERT(lbl, prop)
`define QNBP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> hw/rtl/qnbp_pkg.sv
// ---------------------------------------------------------------------------
// Quadtree node bit packer package
// Shared widths, constants and beat types.
// ---------------------------------------------------------------------------
`default_nettype none

package qnbp_pkg;

  localparam int MAX_LEVELS_DEF = 8;
  localparam int LEVEL_W        = 4;
  localparam int MEAN_W         = 8;
  localparam int ERR_W          = 2;
  localparam int BYTE_W         = 8;
  localparam logic [LEVEL_W-1:0] LEVEL_RST = 4'd8;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic              cmd;
    logic [MEAN_W-1:0] mean;
    logic [ERR_W-1:0]  err;
    logic              uni;
    logic              ignore;
    logic              emit_mean;
    logic              inner;
    logic              has_parent;
  } node_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              eos;
  } out_beat_t;

endpackage

`default_nettype wire

>>> hw/rtl/qnbp_flag_ram.sv
// ---------------------------------------------------------------------------
// Parent flag RAM
// One bit per non-leaf node, one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module qnbp_flag_ram #(
  parameter int DEPTH  = 21845,
  parameter int ADDR_W = 15
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic              wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic              rd_data
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/qnbp_packer.sv
// ---------------------------------------------------------------------------
// Node bit packer stage
// Holds one node beat, merges its bits into the byte buffer, emits up to
// two finished bytes per beat.
// ---------------------------------------------------------------------------
`default_nettype none

module qnbp_packer
  import qnbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  node_beat_t load_beat,
  input  logic       flag_q,
  input  logic       space,
  output logic       ready,
  output logic       push0_vld,
  output out_beat_t  push0,
  output logic       push1_vld,
  output out_beat_t  push1
);

  node_beat_t        stage_r;
  logic              stage_vld_r, stage_vld_nxt;
  logic [BYTE_W-1:0] buf_r, buf_nxt;
  logic [2:0]        fill_r, fill_nxt;

  logic        adv;
  logic        skip;
  logic        live;
  logic        e0;
  logic [2:0]  tail;
  logic [3:0]  tail_n;
  logic [10:0] bits_la;
  logic [3:0]  n;
  logic [23:0] win;
  logic [4:0]  sum;

  always_comb begin
    adv     = stage_vld_r & space;
    ready   = ~stage_vld_r | space;
    skip    = stage_r.has_parent & flag_q;
    live    = adv & ~stage_r.cmd & ~stage_r.ignore & ~skip;
    e0      = (stage_r.err == '0);
    tail    = stage_r.inner ? {stage_r.err, e0 & stage_r.uni} : 3'b000;
    tail_n  = stage_r.inner ? (e0 ? 4'd3 : 4'd2) : 4'd0;
    bits_la = '0;
    n       = 4'd0;
    if (live) begin
      bits_la = stage_r.emit_mean ? {stage_r.mean, tail} : {tail, 8'h00};
      n       = (stage_r.emit_mean ? 4'd8 : 4'd0) + tail_n;
    end
    win = {buf_r, 16'h0000} | ({bits_la, 13'h0000} >> fill_r);
    sum = {2'b00, fill_r} + {1'b0, n};

    push0_vld = 1'b0;
    push1_vld = 1'b0;
    push0     = '{data: win[23:16], last: (sum[4:3] == 2'd1), eos: 1'b0};
    push1     = '{data: win[15:8], last: 1'b1, eos: 1'b0};
    buf_nxt   = buf_r;
    fill_nxt  = fill_r;

    if (adv && stage_r.cmd) begin
      push0_vld = (fill_r != 3'd0);
      push0     = '{data: buf_r, last: 1'b1, eos: 1'b1};
      buf_nxt   = '0;
      fill_nxt  = 3'd0;
    end else if (adv) begin
      push0_vld = (sum[4:3] != 2'd0);
      push1_vld = (sum[4:3] == 2'd2);
      fill_nxt  = sum[2:0];
      case (sum[4:3])
        2'd0:    buf_nxt = win[23:16];
        2'd1:    buf_nxt = win[15:8];
        default: buf_nxt = win[7:0];
      endcase
    end

    stage_vld_nxt = load ? 1'b1 : (adv ? 1'b0 : stage_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
      buf_r       <= '0;
      fill_r      <= 3'd0;
    end else begin
      stage_vld_r <= stage_vld_nxt;
      buf_r       <= buf_nxt;
      fill_r      <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_r <= load_beat;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/qnbp_out_queue.sv
// ---------------------------------------------------------------------------
// Output byte queue
// Small queue taking up to two beats per cycle and giving one.
// ---------------------------------------------------------------------------
`default_nettype none

`include "quadtree_node_bit_packer_top_assert.svh"

module qnbp_out_queue
  import qnbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push0_vld,
  input  out_beat_t push0,
  input  logic      push1_vld,
  input  out_beat_t push1,
  output logic      space,
  output logic      head_vld,
  input  logic      head_rdy,
  output out_beat_t head
);

  out_beat_t             entry [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                  pop;
  logic [OQ_PTR_W-1:0]   wr_ptr_p1;

  always_comb begin
    head_vld   = (cnt_r != '0);
    head       = entry[rd_ptr_r];
    pop        = head_vld & head_rdy;
    space      = (cnt_r <= OQ_CNT_W'(OQ_DEPTH - 2));
    wr_ptr_p1  = wr_ptr_r + 1'b1;
    wr_ptr_nxt = wr_ptr_r + OQ_PTR_W'(push0_vld) + OQ_PTR_W'(push1_vld);
    rd_ptr_nxt = rd_ptr_r + OQ_PTR_W'(pop);
    cnt_nxt    = cnt_r + OQ_CNT_W'(push0_vld) + OQ_CNT_W'(push1_vld) - OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0_vld) begin
      entry[wr_ptr_r] <= push0;
    end
    if (push1_vld) begin
      entry[wr_ptr_p1] <= push1;
    end
  end

  `QNBP_ASSERT(a_cnt_bound, cnt_r <= OQ_CNT_W'(OQ_DEPTH))
  `QNBP_ASSERT(a_pair_room, push1_vld |-> (push0_vld && cnt_r <= OQ_CNT_W'(OQ_DEPTH - 2)))
  `QNBP_ASSERT(a_drain, (pop && !push0_vld) |=> (cnt_r + 1'b1) == $past(cnt_r))
  `QNBP_ASSERT(a_ptr_cnt, (wr_ptr_r - rd_ptr_r) == cnt_r[OQ_PTR_W-1:0])
  `QNBP_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> cnt_r == '0)

endmodule

`default_nettype wire

>>> hw/rtl/quadtree_node_bit_packer_top.sv
// ---------------------------------------------------------------------------
// Quadtree node bit packer
// Packs breadth-first quadtree nodes MSB-first into a byte stream.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per node (in_cmd = 0) or a flush beat (in_cmd = 1).
//           The block counts node indices itself; node beats past the last
//           node of the tree are dropped.
//   out_* : one packed byte per beat; out_last_of_run marks the last byte
//           of an input beat, out_stream_end the byte from a flush.
//   cfg_* : writes num_levels; cfg_ready is always high. Write it only
//           while no beat is in flight.
//   A taken node beat is held in the packing stage; its bytes then pass
//   the byte queue before they are offered. Throughput: one input beat
//   per cycle while beats yield at most one byte; the output side moves
//   one byte per cycle, so runs of two-byte nodes fill the queue. A
//   four-entry byte queue after the packing stage sets this; when the
//   receiver stalls, the queue fills and in_ready drops.
//   Reset: synchronous, clears the node counter, bit buffer and queue;
//   num_levels returns to 8. Parent flags are not cleared; every flag is
//   written before a child reads it.
// ---------------------------------------------------------------------------
`default_nettype none

module quadtree_node_bit_packer_top
  import qnbp_pkg::*;
#(
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [MEAN_W-1:0]  in_node_mean,
  input  logic [ERR_W-1:0]   in_error_code,
  input  logic               in_uniform,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               out_last_of_run,
  output logic               out_stream_end,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LEVEL_W-1:0] cfg_num_levels
);

  localparam int LW         = 2 * MAX_LEVELS + 2;
  localparam int FLAG_DEPTH = ((1 << (2 * MAX_LEVELS)) - 1) / 3;
  localparam int FA_W       = (FLAG_DEPTH > 1) ? $clog2(FLAG_DEPTH) : 1;
  localparam int CNT_W      = $clog2(((1 << LW) - 1) / 3 + 1);
  localparam logic [LW-1:0] EVEN_BITS = LW'(64'h5555_5555_5555_5555);

  logic [LEVEL_W-1:0] num_levels_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic [LEVEL_W-1:0] lv;
  logic [4:0]         tot_sh, inn_sh;
  logic [LW-1:0]      tot_w, inn_w;
  logic [CNT_W-1:0]   total, inner;
  logic [CNT_W-1:0]   idx, par;
  logic               in_fire;
  node_beat_t         beat;

  logic               ram_wr_en, ram_rd_en, flag_q;
  logic               space, pk_ready;
  logic               push0_vld, push1_vld;
  out_beat_t          push0, push1, head;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (num_levels_r == '0) begin
      lv = LEVEL_W'(1);
    end else if (num_levels_r > LEVEL_W'(MAX_LEVELS)) begin
      lv = LEVEL_W'(MAX_LEVELS);
    end else begin
      lv = num_levels_r;
    end
    inn_sh = 5'(LW) - {lv, 1'b0};
    tot_sh = inn_sh - 5'd2;
    tot_w  = EVEN_BITS & ({LW{1'b1}} >> tot_sh);
    inn_w  = EVEN_BITS & ({LW{1'b1}} >> inn_sh);
    total  = tot_w[CNT_W-1:0];
    inner  = inn_w[CNT_W-1:0];

    idx      = cnt_r;
    par      = (idx - 1'b1) >> 2;
    in_ready = pk_ready;
    in_fire  = in_valid & in_ready;

    beat.cmd        = in_cmd;
    beat.mean       = in_node_mean;
    beat.err        = in_error_code;
    beat.uni        = in_uniform;
    beat.ignore     = ~in_cmd & (idx >= total);
    beat.emit_mean  = (idx == '0) | (idx[1:0] != 2'b00);
    beat.inner      = (idx < inner);
    beat.has_parent = (idx != '0);

    ram_rd_en = in_fire & ~in_cmd & beat.has_parent;
    ram_wr_en = in_fire & ~in_cmd & ~beat.ignore & beat.inner;

    cnt_nxt = cnt_r;
    if (in_fire && in_cmd) begin
      cnt_nxt = '0;
    end else if (in_fire && !beat.ignore) begin
      cnt_nxt = idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_levels_r <= LEVEL_RST;
      cnt_r        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        num_levels_r <= cfg_num_levels;
      end
      cnt_r <= cnt_nxt;
    end
  end

  qnbp_flag_ram #(
    .DEPTH  (FLAG_DEPTH),
    .ADDR_W (FA_W)
  ) u_flag_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (idx[FA_W-1:0]),
    .wr_data ((in_error_code == '0) & in_uniform),
    .rd_en   (ram_rd_en),
    .rd_addr (par[FA_W-1:0]),
    .rd_data (flag_q)
  );

  qnbp_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .load_beat (beat),
    .flag_q    (flag_q),
    .space     (space),
    .ready     (pk_ready),
    .push0_vld (push0_vld),
    .push0     (push0),
    .push1_vld (push1_vld),
    .push1     (push1)
  );

  qnbp_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0_vld (push0_vld),
    .push0     (push0),
    .push1_vld (push1_vld),
    .push1     (push1),
    .space     (space),
    .head_vld  (out_valid),
    .head_rdy  (out_ready),
    .head      (head)
  );

  assign out_byte        = head.data;
  assign out_last_of_run = head.last;
  assign out_stream_end  = head.eos;

endmodule

`default_nettype wire
